@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, held off while rst_ni is low
`define MFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen on a clock edge
`define MFD_ASSERT_NEVER(label, cond, msg) \
  `MFD_ASSERT(label, !(cond), msg)

`endif

@@ sv/mfd_pkg.sv @@
package mfd_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  // history depth is taken to be a power of two, pointers wrap naturally
  localparam int unsigned HISTORY_DEPTH = 16384;
  localparam int unsigned IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W        = $clog2(HISTORY_DEPTH + 1);

  localparam int unsigned NUM_TAPS = 6;
  localparam int unsigned STEP_W   = $clog2(NUM_TAPS + 2);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_TAPS + 1);

  localparam int DRY_WEIGHT   = 12;
  localparam int WEIGHT_TOTAL = 12 + 4 + 5 + 5 + 3 + 3 + 4;

  // sum magnitude is at most 36 * 2^(SAMPLE_W-1) < 2^(SAMPLE_W+5)
  localparam int unsigned ACC_W     = SAMPLE_W + 6;
  localparam int unsigned MAG_W     = ACC_W - 1;
  localparam int unsigned PROD_W    = 2 * MAG_W;
  localparam int unsigned DIV_SHIFT = MAG_W + 5;
  localparam logic [MAG_W-1:0] DIV_MULT = MAG_W'((64'd1 << DIV_SHIFT) / WEIGHT_TOTAL);

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic [IDX_W-1:0]        pos;
  } mfd_sum_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [SAMPLE_W-1:0] data;
  } mfd_wr_t;

  function automatic logic [FILL_W-1:0] tap_lag(input logic [STEP_W-1:0] tap);
    logic [FILL_W-1:0] lag;
    unique case (tap)
      STEP_W'(0): lag = FILL_W'(1310);
      STEP_W'(1): lag = FILL_W'(4561);
      STEP_W'(2): lag = FILL_W'(3364);
      STEP_W'(3): lag = FILL_W'(11710);
      STEP_W'(4): lag = FILL_W'(12561);
      STEP_W'(5): lag = FILL_W'(6364);
      default:    lag = '0;
    endcase
    return lag;
  endfunction

  function automatic logic signed [ACC_W-1:0] tap_weight(input logic [STEP_W-1:0] tap);
    logic signed [ACC_W-1:0] w;
    unique case (tap)
      STEP_W'(0): w = ACC_W'(4);
      STEP_W'(1): w = ACC_W'(5);
      STEP_W'(2): w = ACC_W'(5);
      STEP_W'(3): w = ACC_W'(3);
      STEP_W'(4): w = ACC_W'(3);
      STEP_W'(5): w = ACC_W'(4);
      default:    w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ sv/mfd_tap_engine.sv @@
`include "assert_macros.svh"

module mfd_tap_engine
  import mfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                can_start_o,
  output logic                sum_valid_o,
  output mfd_sum_t            sum_o,
  input  logic                sum_ready_i,
  input  mfd_wr_t             wr_i
);

  logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];

  logic                    busy_q, busy_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic                    rd_live_q, rd_live_d;
  logic                    rd_ok_q, rd_ok_d;
  logic [STEP_W-1:0]       rd_tap_q;
  logic [SAMPLE_W-1:0]     rd_data_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic                    hand_fire;
  logic [IDX_W-1:0]        rd_addr;
  logic signed [ACC_W-1:0] tap_ext, dry_ext;

  assign hand_fire   = busy_q && (step_q == LAST_STEP) && sum_ready_i;
  assign can_start_o = !busy_q || hand_fire;
  assign sum_valid_o = busy_q && (step_q == LAST_STEP);
  assign sum_o.acc   = acc_q;
  assign sum_o.pos   = pos_q;

  assign rd_addr = pos_q - IDX_W'(tap_lag(step_q));
  assign tap_ext = {{(ACC_W-SAMPLE_W){rd_data_q[SAMPLE_W-1]}}, rd_data_q};
  assign dry_ext = {{(ACC_W-SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    pos_d  = pos_q;
    fill_d = fill_q;
    acc_d  = acc_q;
    if (hand_fire) begin
      busy_d = 1'b0;
      pos_d  = pos_q + 1'b1;
      if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      acc_d  = dry_ext * ACC_W'(DRY_WEIGHT);
    end else begin
      if (busy_q && (step_q != LAST_STEP)) begin
        step_d = step_q + 1'b1;
      end
      // taps older than the items seen since reset read as zero
      if (rd_live_q && rd_ok_q) begin
        acc_d = acc_q + tap_ext * tap_weight(rd_tap_q);
      end
    end
    rd_live_d = busy_q && (step_q < STEP_W'(NUM_TAPS));
    rd_ok_d   = fill_q >= tap_lag(step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      step_q    <= '0;
      pos_q     <= '0;
      fill_q    <= '0;
      rd_live_q <= 1'b0;
      rd_ok_q   <= 1'b0;
      rd_tap_q  <= '0;
    end else begin
      busy_q    <= busy_d;
      step_q    <= step_d;
      pos_q     <= pos_d;
      fill_q    <= fill_d;
      rd_live_q <= rd_live_d;
      rd_ok_q   <= rd_ok_d;
      rd_tap_q  <= step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr];
  end

  `MFD_ASSERT(a_step_advance,
              busy_q && (step_q != LAST_STEP) && !start_i |=>
              busy_q && (step_q == $past(step_q) + 1'b1),
              "tap sequence stalled mid item")
  `MFD_ASSERT(a_pos_advance, hand_fire |=> pos_q == $past(pos_q) + 1'b1,
              "write position did not advance on hand-off")

endmodule

@@ sv/mfd_divider.sv @@
`include "assert_macros.svh"

module mfd_divider
  import mfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sum_valid_i,
  input  mfd_sum_t            sum_i,
  output logic                sum_ready_o,
  output logic                res_valid_o,
  output logic [SAMPLE_W-1:0] res_sample_o,
  output logic [IDX_W-1:0]    res_pos_o,
  input  logic                res_ready_i
);

  logic              a_valid_q;
  logic [PROD_W-1:0] a_prod_q;
  logic [MAG_W-1:0]  a_mag_q;
  logic              a_neg_q;
  logic [IDX_W-1:0]  a_pos_q;

  logic                    neg;
  logic signed [ACC_W-1:0] acc_abs;
  logic [MAG_W-1:0]        mag;
  logic [SAMPLE_W-1:0]     quo_est, quo;
  logic [MAG_W-1:0]        rem;

  assign sum_ready_o = !a_valid_q || res_ready_i;

  // magnitude times reciprocal, estimate is the quotient or one short
  assign neg     = sum_i.acc[ACC_W-1];
  assign acc_abs = neg ? -sum_i.acc : sum_i.acc;
  assign mag     = acc_abs[MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (sum_ready_o) begin
      a_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready_o && sum_valid_i) begin
      a_prod_q <= PROD_W'(mag) * PROD_W'(DIV_MULT);
      a_mag_q  <= mag;
      a_neg_q  <= neg;
      a_pos_q  <= sum_i.pos;
    end
  end

  assign quo_est = a_prod_q[DIV_SHIFT +: SAMPLE_W];
  assign rem     = a_mag_q - MAG_W'(quo_est) * MAG_W'(WEIGHT_TOTAL);
  assign quo     = (rem >= MAG_W'(WEIGHT_TOTAL)) ? quo_est + 1'b1 : quo_est;

  assign res_valid_o  = a_valid_q;
  assign res_sample_o = a_neg_q ? -quo : quo;
  assign res_pos_o    = a_pos_q;

  `MFD_ASSERT(a_stage_hold, a_valid_q && !res_ready_i |=> a_valid_q && $stable(a_pos_q),
              "divider stage dropped a stalled sum")

endmodule

@@ sv/multitap_feedback_delay_top.sv @@
// Multitap feedback delay: recursive comb over six past outputs.
// Input stream s_axis carries one signed sample per transfer; output stream
// m_axis returns one filtered sample per input, in order:
//   (12*x + 4*y[-1310] + 5*y[-4561] + 5*y[-3364] + 3*y[-11710]
//    + 3*y[-12561] + 4*y[-6364]) / 36, truncated toward zero.
// Past outputs live in a 16384-entry single-read, single-write RAM.
// The tap engine takes one sample at a time: its six tap reads share the one
// RAM read port, with load and hand-off steps, and the next sample starts only
// once the last sum is handed off. On an idle block an input passes the input
// buffer, 8 tap steps and one divider stage into the output register.
// Reset clears all control state; history taps that reach back past reset
// are masked to zero by a saturating fill count, so no clearing pass runs
// and the block accepts data in the first cycle after reset.
// When the receiver stalls the result holds in the output register, one more
// item completes into the divider stage, one finishes its taps and waits in
// the tap engine and one waits in the input buffer, after which s_axis_tready
// drops.
module multitap_feedback_delay_top
  import mfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample_in
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SAMPLE_W-1:0] m_axis_tdata    // [15:0] sample_out
);

  logic                in_valid_q;
  logic [SAMPLE_W-1:0] in_sample_q;
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;

  logic                can_start, start;
  logic                sum_valid, sum_ready;
  mfd_sum_t            sum;
  logic                res_valid, res_ready;
  logic [SAMPLE_W-1:0] res_sample;
  logic [IDX_W-1:0]    res_pos;
  mfd_wr_t             wr;

  assign start         = in_valid_q && can_start;
  assign s_axis_tready = !in_valid_q || start;
  assign res_ready     = !out_valid_q || m_axis_tready;

  // every result goes back into the history as it enters the output register
  assign wr.en   = res_valid && res_ready;
  assign wr.addr = res_pos;
  assign wr.data = res_sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (res_ready) begin
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample_q <= s_axis_tdata;
    end
    if (wr.en) begin
      out_sample_q <= res_sample;
    end
  end

  mfd_tap_engine u_tap_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .sample_i    (in_sample_q),
    .can_start_o (can_start),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .sum_ready_i (sum_ready),
    .wr_i        (wr)
  );

  mfd_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sum_valid_i  (sum_valid),
    .sum_i        (sum),
    .sum_ready_o  (sum_ready),
    .res_valid_o  (res_valid),
    .res_sample_o (res_sample),
    .res_pos_o    (res_pos),
    .res_ready_i  (res_ready)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import mfd_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int WIND_DOWN   = 20;
  localparam int DRY_GAIN    = 12;
  localparam int GAIN_TOTAL  = 36;
  localparam int ECHO_TAPS   = 6;

  localparam logic [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata  = '0;  // [15:0] sample_in
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;        // [15:0] sample_out

  // own copy of the output history and its write pointer
  logic signed [SAMPLE_W-1:0] echo_mem [HISTORY_DEPTH];
  logic [IDX_W-1:0]           echo_wr;

  logic [SAMPLE_W-1:0] pending_samples [$];
  logic [SAMPLE_W-1:0] expected_out [$];

  idle_mode_e idle_mode    = IDLE_NONE;
  int         hold_left    = 0;
  int         quiet_cycles = 0;
  int         mismatches   = 0;
  int         samples_in   = 0;
  int         samples_out  = 0;

  multitap_feedback_delay_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int echo_lag(input int tap);
    case (tap)
      0: return 1310;
      1: return 4561;
      2: return 3364;
      3: return 11710;
      4: return 12561;
      5: return 6364;
      default: return 0;
    endcase
  endfunction

  function automatic int echo_gain(input int tap);
    case (tap)
      0, 5: return 4;
      1, 2: return 5;
      3, 4: return 3;
      default: return 0;
    endcase
  endfunction

  // weighted sum of the new sample and six past outputs, divided toward zero
  task automatic filter_sample(input logic [SAMPLE_W-1:0] x);
    int                         acc;
    logic [IDX_W-1:0]           rd;
    logic signed [SAMPLE_W-1:0] y;
    acc = DRY_GAIN * int'($signed(x));
    for (int k = 0; k < ECHO_TAPS; k++) begin
      rd  = echo_wr - IDX_W'(echo_lag(k));
      acc += echo_gain(k) * int'(echo_mem[rd]);
    end
    y = SAMPLE_W'(acc / GAIN_TOTAL);
    echo_mem[echo_wr] = y;
    echo_wr = echo_wr + 1'b1;
    expected_out.push_back(y);
  endtask

  function automatic bit idle_draw(input idle_mode_e own);
    if (idle_mode == own) return $urandom_range(0, 99) < 70;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 16;
    return 1'b0;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return FULL_POS;
      1: return FULL_NEG;
      2: return SAMPLE_W'($urandom_range(0, 15)) - SAMPLE_W'(8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // queues samples, with the odd long run of full scale to drive the feedback hard
  task automatic run_phase(input idle_mode_e mode, input int count);
    int                  pushed;
    logic [SAMPLE_W-1:0] level;
    pushed    = 0;
    idle_mode = mode;
    while (pushed < count) begin
      if ($urandom_range(0, 49) == 0) begin
        level = $urandom_range(0, 1) ? FULL_POS : FULL_NEG;
        repeat (40) pending_samples.push_back(level);
        pushed += 40;
      end else begin
        pending_samples.push_back(pick_sample());
        pushed++;
      end
    end
    while (pending_samples.size() > 0) @(negedge clk_i);
  endtask

  // sender: holds tvalid and tdata steady until the transfer completes
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        filter_sample(s_axis_tdata);
        samples_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() > 0 && !idle_draw(IDLE_SEND)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_samples.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= SAMPLE_W'($urandom);
        end
      end
    end
  end

  // receiver: checks each output transfer against the oldest prediction
  always @(posedge clk_i) begin : output_check
    logic [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        samples_out++;
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("output %h with nothing outstanding", m_axis_tdata));
        end else begin
          want = expected_out.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("sample_out %0d: got %h, want %h",
                                      samples_out - 1, m_axis_tdata, want));
        end
      end
      if (hold_left > 0) hold_left--;
      m_axis_tready <= (hold_left == 0) && !idle_draw(IDLE_RECV);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < HISTORY_DEPTH; i++) echo_mem[i] = '0;
    echo_wr = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // full-scale runs, zero, unit steps and bit patterns while taps still read zeros
    repeat (6) pending_samples.push_back(FULL_POS);
    repeat (6) pending_samples.push_back(FULL_NEG);
    pending_samples.push_back('0);
    pending_samples.push_back('1);
    pending_samples.push_back(SAMPLE_W'(1));
    pending_samples.push_back({(SAMPLE_W/2){2'b01}});
    pending_samples.push_back({(SAMPLE_W/2){2'b10}});
    pending_samples.push_back(FULL_NEG | SAMPLE_W'(1));
    pending_samples.push_back(FULL_POS - SAMPLE_W'(1));
    pending_samples.push_back(SAMPLE_W'(GAIN_TOTAL));
    pending_samples.push_back(-SAMPLE_W'(GAIN_TOTAL));

    // long receiver hold-off while the sender keeps offering, fills the pipeline
    hold_left = HOLD_CYCLES;
    run_phase(IDLE_NONE, 380);
    run_phase(IDLE_SEND, 380);
    run_phase(IDLE_RECV, 380);
    run_phase(IDLE_BOTH, 380);

    idle_mode = IDLE_NONE;
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_out.size() > 0)
      @(negedge clk_i);
    repeat (WIND_DOWN) @(negedge clk_i);

    $display("%0d samples in, %0d filtered outputs checked, feedback from the shortest tap on",
             samples_in, samples_out);
    $display("ran with no idling, sender gaps, receiver stalls, both, and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
